FILE: rtl/mdrq_pkg.sv
// Shared types and constants of the motion duty ratio qualifier.
package mdrq_pkg;

  localparam int MS_PER_S   = 1000;
  localparam int PERCENT    = 100;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int THR_W      = 7;
  localparam int LIM_W      = 23;
  localparam int LOAD_W     = 22;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVATION = 2'd0,
    REG_RATIO      = 2'd1,
    REG_TIMEOUT    = 2'd2
  } mdrq_reg_e;

  typedef struct packed {
    logic tick;
    logic check;
    logic window_open;
  } mdrq_side_t;

endpackage

FILE: rtl/motion_duty_ratio_qualifier_core.sv
// Top level of the motion duty ratio qualifier.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    action_i, level_i, time_ms_i
//   out      output     out_valid_o / out_stall_i  motion_confirmed_o,
//                                                  inactivity_timeout_o,
//                                                  presence_active_o, window_open_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One transaction is accepted per cycle while in_stall_o is low; its result is
// registered in turn by the window stage, the divide-by-thousand multiplier stage
// and the ratio and countdown stage.
// Reset clears all window and countdown state and loads the register defaults.
// A stalled output holds its result while empty stages ahead still take input.
module motion_duty_ratio_qualifier_core import mdrq_pkg::*; #(
  parameter int TIME_WIDTH      = 32,
  parameter int COUNTDOWN_WIDTH = 22
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic                  level_i,
  input  logic [TIME_WIDTH-1:0] time_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  motion_confirmed_o,
  output logic                  inactivity_timeout_o,
  output logic                  presence_active_o,
  output logic                  window_open_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int QW = TIME_WIDTH - 9;
  localparam logic [32:0] CD_MAX = (33'(1) << COUNTDOWN_WIDTH) - 33'(1);

  function automatic logic [LIM_W-1:0] lim_of(logic [CFG_DATA_W-1:0] secs);
    return LIM_W'(LIM_W'(secs) + LIM_W'(1)) * LIM_W'(MS_PER_S);
  endfunction

  function automatic logic [COUNTDOWN_WIDTH-1:0] load_of(logic [CFG_DATA_W-1:0] secs);
    logic [LOAD_W-1:0] full;
    logic [32:0]       ext;
    full = LOAD_W'(secs) * LOAD_W'(MS_PER_S);
    ext  = 33'(full);
    if (ext > CD_MAX) begin
      ext = CD_MAX;
    end
    return ext[COUNTDOWN_WIDTH-1:0];
  endfunction

  logic [LIM_W-1:0]           act_lim_q;
  logic [THR_W-1:0]           thr_q;
  logic [COUNTDOWN_WIDTH-1:0] cd_load_q;
  logic                       v1_q, v2_q, vo_q;
  logic                       adv_1, adv_2, adv_o, accept;
  mdrq_side_t                 s1_side, s2_side_q;
  logic [TIME_WIDTH-1:0]      s1_act, s1_el;
  logic [QW-1:0]              act_s, el_s;
  mdrq_reg_e                  cfg_reg;

  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = mdrq_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_lim_q <= lim_of(CFG_DATA_W'(10));
      thr_q     <= THR_W'(50);
      cd_load_q <= load_of(CFG_DATA_W'(60));
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg)
        REG_ACTIVATION: act_lim_q <= lim_of(cfg_data_i);
        REG_RATIO:      thr_q     <= cfg_data_i[THR_W-1:0];
        REG_TIMEOUT:    cd_load_q <= load_of(cfg_data_i);
        default:        ;
      endcase
    end
  end

  assign adv_o      = !vo_q || !out_stall_i;
  assign adv_2      = !v2_q || adv_o;
  assign adv_1      = !v1_q || adv_2;
  assign in_stall_o = !adv_1;
  assign accept     = in_valid_i && adv_1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv_1) begin
        v1_q <= in_valid_i;
      end
      if (adv_2) begin
        v2_q <= v1_q;
      end
      if (adv_o) begin
        vo_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_2) begin
      s2_side_q <= s1_side;
    end
  end

  mdrq_window #(
    .TW(TIME_WIDTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .load_i    (adv_1),
    .action_i  (action_i),
    .level_i   (level_i),
    .time_i    (time_ms_i),
    .act_lim_i (act_lim_q),
    .side_o    (s1_side),
    .act_o     (s1_act),
    .el_o      (s1_el)
  );

  mdrq_div1000 #(
    .TW(TIME_WIDTH)
  ) u_div_act (
    .clk_i  (clk_i),
    .load_i (adv_2),
    .x_i    (s1_act),
    .q_o    (act_s)
  );

  mdrq_div1000 #(
    .TW(TIME_WIDTH)
  ) u_div_el (
    .clk_i  (clk_i),
    .load_i (adv_2),
    .x_i    (s1_el),
    .q_o    (el_s)
  );

  mdrq_countdown #(
    .QW(QW),
    .CW(COUNTDOWN_WIDTH)
  ) u_countdown (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (adv_o && v2_q),
    .side_i        (s2_side_q),
    .act_s_i       (act_s),
    .el_s_i        (el_s),
    .thr_i         (thr_q),
    .cd_load_i     (cd_load_q),
    .confirmed_o   (motion_confirmed_o),
    .timeout_o     (inactivity_timeout_o),
    .presence_o    (presence_active_o),
    .window_open_o (window_open_o)
  );

  assign out_valid_o = vo_q;

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(motion_confirmed_o && inactivity_timeout_o))
    else $error("confirmation and timeout in one result");

  a_conf_presence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && motion_confirmed_o) |-> presence_active_o)
    else $error("confirmation did not start the countdown");

  a_timeout_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inactivity_timeout_o) |-> !presence_active_o)
    else $error("countdown still running after timeout");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && vo_q && out_stall_i) |-> in_stall_o)
    else $error("input taken while the pipeline is full and stalled");

endmodule

FILE: rtl/mdrq_window.sv
// Observation window state and first pipeline stage of the qualifier.
module mdrq_window import mdrq_pkg::*; #(
  parameter int TW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                load_i,
  input  logic                action_i,
  input  logic                level_i,
  input  logic [TW-1:0]       time_i,
  input  logic [LIM_W-1:0]    act_lim_i,
  output mdrq_side_t          side_o,
  output logic [TW-1:0]       act_o,
  output logic [TW-1:0]       el_o
);

  localparam int CMP_W = (TW > LIM_W) ? TW : LIM_W;

  logic          flag_q, flag_d;
  logic [TW-1:0] start_q, start_d;
  logic [TW-1:0] last_q, last_d;
  logic [TW-1:0] tot_q, tot_d;
  logic [TW-1:0] el, tot_sum, act_val;
  logic          hit;
  mdrq_side_t    side_q;
  logic [TW-1:0] act_q, el_q;

  always_comb begin
    el      = time_i - start_q;
    tot_sum = tot_q + (time_i - last_q);
    hit     = flag_q && (CMP_W'(el) >= CMP_W'(act_lim_i));
    act_val = level_i ? tot_q : tot_sum;
    flag_d  = flag_q;
    start_d = start_q;
    last_d  = last_q;
    tot_d   = tot_q;
    if (!action_i) begin
      if (flag_q) begin
        if (!level_i) begin
          tot_d = tot_sum;
        end
        if (hit) begin
          flag_d  = 1'b0;
          start_d = '0;
          last_d  = '0;
          tot_d   = '0;
        end
      end
      if (level_i) begin
        if (!flag_d) begin
          flag_d  = 1'b1;
          start_d = time_i;
        end
        last_d = time_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q  <= 1'b0;
      start_q <= '0;
      last_q  <= '0;
      tot_q   <= '0;
    end else if (accept_i) begin
      flag_q  <= flag_d;
      start_q <= start_d;
      last_q  <= last_d;
      tot_q   <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      side_q.tick        <= action_i;
      side_q.check       <= !action_i && hit;
      side_q.window_open <= flag_d;
      act_q              <= act_val;
      el_q               <= el;
    end
  end

  assign side_o = side_q;
  assign act_o  = act_q;
  assign el_o   = el_q;

endmodule

FILE: rtl/mdrq_div1000.sv
// Registered division of a millisecond count by one thousand.
module mdrq_div1000 import mdrq_pkg::*; #(
  parameter int TW = 32
) (
  input  logic          clk_i,
  input  logic          load_i,
  input  logic [TW-1:0] x_i,
  output logic [TW-10:0] q_o
);

  localparam int YW = TW - 3;
  localparam int QW = TW - 9;
  localparam int SH = YW + 7;
  localparam int PW = 2 * YW + 1;
  localparam logic [SH:0] POW = {1'b1, {SH{1'b0}}};
  localparam logic [SH:0] RECIP_FULL = (POW + (SH+1)'(124)) / (SH+1)'(125);
  localparam logic [YW:0] RECIP = RECIP_FULL[YW:0];

  logic [YW-1:0] y;
  logic [PW-1:0] prod_q;

  // The low three bits divide out exactly, what is left is a division by 125.
  assign y = x_i[TW-1:3];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= PW'(y) * PW'(RECIP);
    end
  end

  assign q_o = prod_q[SH +: QW];

endmodule

FILE: rtl/mdrq_countdown.sv
// Ratio check, inactivity countdown and result register of the qualifier.
module mdrq_countdown import mdrq_pkg::*; #(
  parameter int QW = 23,
  parameter int CW = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  mdrq_side_t       side_i,
  input  logic [QW-1:0]    act_s_i,
  input  logic [QW-1:0]    el_s_i,
  input  logic [THR_W-1:0] thr_i,
  input  logic [CW-1:0]    cd_load_i,
  output logic             confirmed_o,
  output logic             timeout_o,
  output logic             presence_o,
  output logic             window_open_o
);

  localparam int MW = QW + THR_W;

  logic [MW-1:0] lhs, rhs;
  logic          ok, to;
  logic          run_q, run_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          conf_q, to_q, wopen_q;

  always_comb begin
    lhs   = MW'(act_s_i) * MW'(PERCENT);
    rhs   = MW'(thr_i) * MW'(el_s_i);
    ok    = side_i.check && (lhs >= rhs);
    to    = 1'b0;
    run_d = run_q;
    cnt_d = cnt_q;
    if (side_i.tick) begin
      if (run_q) begin
        if (cnt_q <= CW'(1)) begin
          cnt_d = '0;
          run_d = 1'b0;
          to    = 1'b1;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
    end else if (ok) begin
      cnt_d = cd_load_i;
      run_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (take_i) begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      conf_q  <= ok;
      to_q    <= to;
      wopen_q <= side_i.window_open;
    end
  end

  assign confirmed_o   = conf_q;
  assign timeout_o     = to_q;
  assign presence_o    = run_q;
  assign window_open_o = wopen_q;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the motion duty ratio qualifier core.
`timescale 1ns / 100ps

module tb_top;
  import mdrq_pkg::*;

  localparam int TIME_W = 32;
  localparam int CD_W   = 22;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic {
    ACT_EDGE = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef enum logic {
    ROW_EVENT,
    ROW_REG
  } row_kind_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  typedef struct packed {
    logic confirmed;
    logic timeout;
    logic presence;
    logic window;
  } qual_result_t;

  typedef struct packed {
    action_e           action;
    logic              level;
    logic [TIME_W-1:0] time_ms;
    logic              typed;
    qual_result_t      want;
  } sensor_event_t;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    sensor_event_t         ev;
  } directed_row_t;

  logic                  clk;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  sensor_event_t         cur_ev    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  qual_result_t          dut_res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic [11:0]       act_s;
  logic [THR_W-1:0]  thr_pct;
  logic [11:0]       tmo_s;
  logic              win_open     = 1'b0;
  logic [TIME_W-1:0] win_start_ms = '0;
  logic [TIME_W-1:0] rise_ms      = '0;
  logic [TIME_W-1:0] active_ms    = '0;
  logic              cd_running   = 1'b0;
  logic [CD_W-1:0]   cd_ms        = '0;

  sensor_event_t sensor_events[$];
  qual_result_t  pending_results[$];
  directed_row_t directed_rows[$];

  int unsigned mismatches   = 0;
  int unsigned checked      = 0;
  int unsigned confirm_seen = 0;
  int unsigned timeout_seen = 0;
  int unsigned reg_writes   = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  motion_duty_ratio_qualifier_core #(
    .TIME_WIDTH      (TIME_W),
    .COUNTDOWN_WIDTH (CD_W)
  ) i_dut (
    .clk_i                (clk),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .action_i             (cur_ev.action),
    .level_i              (cur_ev.level),
    .time_ms_i            (cur_ev.time_ms),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .motion_confirmed_o   (dut_res.confirmed),
    .inactivity_timeout_o (dut_res.timeout),
    .presence_active_o    (dut_res.presence),
    .window_open_o        (dut_res.window),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic qual_result_t qualify_step(sensor_event_t ev);
    qual_result_t      res;
    logic [TIME_W-1:0] span_ms;
    logic [TIME_W-1:0] span_s;
    logic [TIME_W-1:0] busy_s;
    logic [63:0]       load;
    res = '0;
    if (ev.action == ACT_EDGE) begin
      if (win_open) begin
        span_ms = ev.time_ms - win_start_ms;
        span_s  = span_ms / 32'(MS_PER_S);
        if (!ev.level) begin
          active_ms = active_ms + (ev.time_ms - rise_ms);
        end
        if (span_s > 32'(act_s)) begin
          busy_s = active_ms / 32'(MS_PER_S);
          if (64'(busy_s) * 64'(PERCENT) >= 64'(thr_pct) * 64'(span_s)) begin
            res.confirmed = 1'b1;
            load          = 64'(tmo_s) * 64'(MS_PER_S);
            cd_ms         = (load > 64'({CD_W{1'b1}})) ? {CD_W{1'b1}} : load[CD_W-1:0];
            cd_running    = 1'b1;
          end
          win_open     = 1'b0;
          win_start_ms = '0;
          rise_ms      = '0;
          active_ms    = '0;
        end
      end
      if (ev.level) begin
        if (!win_open) begin
          win_open     = 1'b1;
          win_start_ms = ev.time_ms;
        end
        rise_ms = ev.time_ms;
      end
    end else if (cd_running) begin
      if (cd_ms <= CD_W'(1)) begin
        cd_ms       = '0;
        cd_running  = 1'b0;
        res.timeout = 1'b1;
      end else begin
        cd_ms = cd_ms - CD_W'(1);
      end
    end
    res.presence = cd_running;
    res.window   = win_open;
    return res;
  endfunction

  function automatic void compare_bit(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %b, actual %b", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(qual_result_t got);
    qual_result_t want;
    if (pending_results.size() == 0) begin
      $error("Unexpected result %b with no transaction pending", got);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    compare_bit("motion_confirmed", want.confirmed, got.confirmed);
    compare_bit("inactivity_timeout", want.timeout, got.timeout);
    compare_bit("presence_active", want.presence, got.presence);
    compare_bit("window_open", want.window, got.window);
    checked++;
    confirm_seen += 32'(got.confirmed);
    timeout_seen += 32'(got.timeout);
  endfunction

  always @(posedge clk) begin
    qual_result_t predicted;
    if (rst_ni && in_valid && !in_stall) begin
      predicted = qualify_step(cur_ev);
      pending_results.push_back(cur_ev.typed ? cur_ev.want : predicted);
    end
    if (rst_ni && out_valid && !out_stall) begin
      check_result(dut_res);
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= !out_stall;
    endcase
  end

  function automatic void push_event(action_e act, logic lvl, logic [TIME_W-1:0] t);
    sensor_event_t ev;
    ev         = '0;
    ev.action  = act;
    ev.level   = lvl;
    ev.time_ms = t;
    sensor_events.push_back(ev);
  endfunction

  function automatic void push_ticks();
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4)) push_event(ACT_TICK, 1'($urandom_range(0, 1)), $urandom);
    end
  endfunction

  // One observation window: a rise, a few edges of mixed level, and a closing
  // edge placed near the activation time so that checks both run and wait.
  function automatic void push_window();
    logic [TIME_W-1:0] base;
    int unsigned       span;
    int unsigned       edges;
    int unsigned       slot;
    logic              lvl;
    base  = $urandom;
    span  = (act_s + $urandom_range(0, 3)) * 1000 + $urandom_range(0, 999);
    edges = $urandom_range(1, 6);
    slot  = span / (edges + 1);
    lvl   = 1'b1;
    push_event(ACT_EDGE, 1'b1, base);
    for (int j = 1; j <= edges; j++) begin
      push_ticks();
      lvl = ($urandom_range(0, 7) == 0) ? lvl : !lvl;
      push_event(ACT_EDGE, lvl, base + slot * j + $urandom_range(0, slot));
    end
    push_ticks();
    push_event(ACT_EDGE, 1'($urandom_range(0, 1)), base + span);
  endfunction

  function automatic void add_event_row(action_e act, logic lvl, logic [TIME_W-1:0] t,
                                        logic typed, qual_result_t want);
    directed_row_t row;
    row.kind       = ROW_EVENT;
    row.reg_idx    = '0;
    row.reg_data   = '0;
    row.ev.action  = act;
    row.ev.level   = lvl;
    row.ev.time_ms = t;
    row.ev.typed   = typed;
    row.ev.want    = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    directed_row_t row;
    row.kind     = ROW_REG;
    row.reg_idx  = idx;
    row.reg_data = data;
    row.ev       = '0;
    directed_rows.push_back(row);
  endfunction

  task automatic send_events();
    int unsigned burst;
    int unsigned gap;
    while (sensor_events.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && sensor_events.size() != 0) begin
        in_valid <= 1'b1;
        cur_ev   <= sensor_events.pop_front();
        do @(posedge clk); while (in_stall);
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0 && sensor_events.size() != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ACTIVATION: act_s   = data;
      REG_RATIO:      thr_pct = data[THR_W-1:0];
      REG_TIMEOUT:    tmo_s   = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] act, logic [CFG_DATA_W-1:0] thr,
                              logic [CFG_DATA_W-1:0] tmo);
    wait_drained();
    set_reg(REG_ACTIVATION, act);
    set_reg(REG_RATIO, thr);
    set_reg(REG_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    act_s   = 12'd10;
    thr_pct = 7'd50;
    tmo_s   = 12'd60;

    // Typed results are packed as {confirmed, timeout, presence, window}.
    add_event_row(ACT_TICK, 1'b1, 32'h1234_5678, 1'b1, 4'b0000);
    add_event_row(ACT_EDGE, 1'b0, 32'hFFFF_FFFF, 1'b1, 4'b0000);
    add_event_row(ACT_EDGE, 1'b1, 32'hFFFF_F000, 1'b1, 4'b0001);
    add_event_row(ACT_EDGE, 1'b0, 32'h0000_2000, 1'b0, '0);
    add_event_row(ACT_TICK, 1'b0, 32'h0, 1'b0, '0);
    add_event_row(ACT_EDGE, 1'b1, 32'd0, 1'b0, '0);
    add_event_row(ACT_EDGE, 1'b1, 32'd500, 1'b0, '0);
    add_event_row(ACT_EDGE, 1'b0, 32'd1500, 1'b0, '0);
    add_event_row(ACT_EDGE, 1'b0, 32'd2500, 1'b0, '0);
    add_event_row(ACT_EDGE, 1'b1, 32'd11000, 1'b0, '0);
    add_event_row(ACT_EDGE, 1'b0, 32'd22000, 1'b0, '0);
    add_reg_row(REG_ACTIVATION, 12'd0);
    add_reg_row(REG_RATIO, 12'd0);
    add_reg_row(REG_TIMEOUT, 12'd0);
    add_event_row(ACT_EDGE, 1'b1, 32'd1000, 1'b0, '0);
    add_event_row(ACT_EDGE, 1'b1, 32'd1999, 1'b0, '0);
    add_event_row(ACT_EDGE, 1'b0, 32'd2000, 1'b0, '0);
    add_event_row(ACT_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'b0100);
    add_event_row(ACT_TICK, 1'b0, 32'h0, 1'b1, 4'b0000);
    add_reg_row(REG_ACTIVATION, 12'hFFF);
    add_reg_row(REG_RATIO, 12'd127);
    add_reg_row(REG_TIMEOUT, 12'hFFF);
    add_event_row(ACT_EDGE, 1'b1, 32'd0, 1'b0, '0);
    add_event_row(ACT_EDGE, 1'b0, 32'd4096000, 1'b0, '0);
    add_reg_row(REG_ACTIVATION, 12'd1);
    add_reg_row(REG_RATIO, 12'hF64);
    add_event_row(ACT_EDGE, 1'b1, 32'h8000_0000, 1'b0, '0);
    add_event_row(ACT_EDGE, 1'b0, 32'h8000_07D0, 1'b0, '0);
    add_event_row(ACT_TICK, 1'b0, 32'h0, 1'b0, '0);
    add_reg_row(REG_SPARE, 12'hFFF);
    add_reg_row(REG_TIMEOUT, 12'd1);
    add_event_row(ACT_EDGE, 1'b1, 32'd0, 1'b0, '0);
    add_event_row(ACT_EDGE, 1'b0, 32'd3000, 1'b0, '0);
    add_event_row(ACT_TICK, 1'b1, 32'h0, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_REG) begin
          send_events();
          wait_drained();
        end
        set_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
        if (i + 1 == directed_rows.size() || directed_rows[i+1].kind != ROW_REG) begin
          cfg_valid <= 1'b0;
        end
      end else begin
        sensor_events.push_back(directed_rows[i].ev);
      end
    end
    send_events();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_regs(12'd0, 12'd0, 12'd0);
        1: program_regs(12'hFFF, 12'd127, 12'hFFF);
        2: program_regs(12'd1, 12'hF64, 12'd0);
        default: program_regs(12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                               : $urandom_range(0, 20)),
                              12'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                              : $urandom_range(20, 80)),
                              12'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095)
                                                              : 0));
      endcase
      while (sensor_events.size() < 50) begin
        if ($urandom_range(0, 6) == 0) begin
          push_event(action_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
        end else begin
          push_window();
        end
      end
      send_events();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Checked %0d transactions with %0d register writes across directed and random phases.",
             checked, reg_writes);
    $display("Saw %0d motion confirmations and %0d inactivity timeouts.",
             confirm_seen, timeout_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Run did not finish in time.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mdrq_pkg.sv
rtl/mdrq_window.sv
rtl/mdrq_div1000.sv
rtl/mdrq_countdown.sv
rtl/motion_duty_ratio_qualifier_core.sv
test/tb_top.sv
